// File: rtl/tcrd_pkg.sv
// shared types and constants for the typed column record decoder
package tcrd_pkg;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SKIP_INDEX   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_OFFSET  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_COLUMN = 2'd0;
   localparam logic [1:0] KIND_ERROR  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   // reported value types
   localparam logic [2:0] VT_INTEGER = 3'd0;
   localparam logic [2:0] VT_FLOAT   = 3'd1;
   localparam logic [2:0] VT_TEXT    = 3'd2;
   localparam logic [2:0] VT_BLOB    = 3'd3;
   localparam logic [2:0] VT_NULL    = 3'd4;
   localparam logic [2:0] VT_SLICE   = 3'd5;

   // column type codes in the type byte
   localparam logic [2:0] CT_NEG_INT   = 3'd0;
   localparam logic [2:0] CT_INT       = 3'd1;
   localparam logic [2:0] CT_FLOAT     = 3'd2;
   localparam logic [2:0] CT_TEXT      = 3'd3;
   localparam logic [2:0] CT_BLOB      = 3'd4;
   localparam logic [2:0] CT_NULL      = 3'd5;
   localparam logic [2:0] CT_MIN_INT   = 3'd6;
   localparam logic [2:0] CT_NEG_FLOAT = 3'd7;

   // error causes
   localparam logic CAUSE_TRUNCATED  = 1'b0;
   localparam logic CAUSE_BAD_LENGTH = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         column_index;
      logic [2:0]         value_type;
      logic signed [63:0] int_value;
      logic [63:0]        float_bits;
      logic [31:0]        data_offset;
      logic               error_cause;
      logic [7:0]         column_total;
      logic [31:0]        end_offset;
      logic               is_last;
   } rsp_type;

   typedef struct packed {
      logic signed [8:0] column_count;
      logic signed [8:0] skip_index;
      logic [31:0]       base_offset;
   } cfg_type;

   // results produced by one byte, first slot leads
   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot0;
      rsp_type    slot1;
   } push_type;

endpackage

// File: rtl/tcrd_csr.sv
// configuration registers of the record decoder
module tcrd_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [tcrd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tcrd_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output tcrd_pkg::cfg_type                      cfg
);
   import tcrd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_COLUMN_COUNT: cfg_in.column_count = csr_wdata[8:0];
            CSR_SKIP_INDEX:   cfg_in.skip_index   = csr_wdata[8:0];
            CSR_BASE_OFFSET:  cfg_in.base_offset  = csr_wdata[31:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_count <= -9'sd1;
         cfg_ff.skip_index   <= -9'sd1;
         cfg_ff.base_offset  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/tcrd_parse.sv
// running parse state and per-byte result generation
module tcrd_parse #(
   parameter int OFFSET_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  tcrd_pkg::cfg_type  cfg,
   input  logic               in_accept,
   input  tcrd_pkg::req_type  req,
   output tcrd_pkg::push_type push
);
   import tcrd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_COUNT,
      PH_TYPE,
      PH_FIELD,
      PH_PAYLOAD,
      PH_HALT
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [7:0]             columns_left_ff, columns_left_in;
   logic [7:0]             column_number_ff, column_number_in;
   logic [2:0]             current_type_ff, current_type_in;
   logic [4:0]             type_length_ff, type_length_in;
   logic [3:0]             field_left_ff, field_left_in;
   logic [63:0]            accumulator_ff, accumulator_in;
   logic [63:0]            payload_left_ff, payload_left_in;
   logic [OFFSET_BITS-1:0] byte_position_ff, byte_position_in;
   logic [OFFSET_BITS-1:0] column_start_ff, column_start_in;
   logic [OFFSET_BITS-1:0] payload_start_ff, payload_start_in;

   // buffer offset: wraps at the offset width, then cut to 32 bits
   function automatic logic [31:0] buf_offset(input logic [31:0] base,
                                              input logic [OFFSET_BITS-1:0] pos);
      logic [OFFSET_BITS-1:0] sum;
      sum = OFFSET_BITS'(base) + pos;
      return 32'(sum);
   endfunction

   // next state and results for the byte on the input
   always_comb begin
      logic                   run;
      logic                   active;
      logic                   fin;
      logic                   done;
      logic                   ill;
      logic                   trunc;
      logic                   skip;
      logic                   len_ok;
      logic                   is_float;
      logic [2:0]             t;
      logic [4:0]             len;
      logic [2:0]             lane;
      logic [63:0]            slice;
      logic [OFFSET_BITS-1:0] pos;
      rsp_type                col_res;
      rsp_type                done_res;
      rsp_type                err_res;
      logic [1:0]             n;

      phase_in         = phase_ff;
      columns_left_in  = columns_left_ff;
      column_number_in = column_number_ff;
      current_type_in  = current_type_ff;
      type_length_in   = type_length_ff;
      field_left_in    = field_left_ff;
      accumulator_in   = accumulator_ff;
      payload_left_in  = payload_left_ff;
      byte_position_in = byte_position_ff;
      column_start_in  = column_start_ff;
      payload_start_in = payload_start_ff;

      run      = 1'b1;
      active   = 1'b0;
      fin      = 1'b0;
      done     = 1'b0;
      ill      = 1'b0;
      trunc    = 1'b0;
      skip     = 1'b0;
      len_ok   = 1'b0;
      is_float = 1'b0;
      t        = req.data_byte[2:0];
      len      = req.data_byte[7:3];
      lane     = '0;
      slice    = '0;
      pos      = byte_position_ff;
      col_res  = '0;
      done_res = '0;
      err_res  = '0;

      // restart on the first byte of a buffer
      if (req.first_byte) begin
         byte_position_in = '0;
         column_number_in = '0;
         accumulator_in   = '0;
         payload_left_in  = '0;
         field_left_in    = '0;
         column_start_in  = '0;
         payload_start_in = '0;
         if (cfg.column_count[8]) begin
            phase_in = PH_COUNT;
         end else begin
            columns_left_in = cfg.column_count[7:0];
            if (columns_left_in == 8'd0) begin
               // empty record: done at once, byte not consumed
               done     = 1'b1;
               run      = 1'b0;
               phase_in = PH_HALT;
            end else begin
               phase_in = PH_TYPE;
            end
         end
      end

      // consume the byte
      if (run && phase_in != PH_IDLE && phase_in != PH_HALT) begin
         active           = 1'b1;
         pos              = byte_position_in;
         byte_position_in = byte_position_in + OFFSET_BITS'(1);
         case (phase_in)
            PH_COUNT: begin
               columns_left_in = req.data_byte;
               if (req.data_byte == 8'd0) begin
                  done     = 1'b1;
                  phase_in = PH_HALT;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               column_start_in = pos;
               current_type_in = t;
               type_length_in  = len;
               accumulator_in  = '0;
               if (t == CT_NEG_INT || t == CT_INT || t == CT_TEXT || t == CT_BLOB) begin
                  len_ok = (len >= 5'd1) && (len <= 5'd8);
               end else begin
                  len_ok = (len == 5'd0);
               end
               if (!len_ok) begin
                  ill      = 1'b1;
                  phase_in = PH_HALT;
               end else if (t == CT_NULL || t == CT_MIN_INT) begin
                  fin = 1'b1;
               end else begin
                  is_float      = (t == CT_FLOAT) || (t == CT_NEG_FLOAT);
                  field_left_in = is_float ? 4'd8 : len[3:0];
                  phase_in      = PH_FIELD;
               end
            end
            PH_FIELD: begin
               is_float = (current_type_in == CT_FLOAT) || (current_type_in == CT_NEG_FLOAT);
               if (is_float) begin
                  // float bytes land least significant first
                  lane = 3'(4'd8 - field_left_in);
                  for (int k = 0; k < 8; k++) begin
                     if (lane == 3'(k)) begin
                        accumulator_in[8*k +: 8] = accumulator_in[8*k +: 8] | req.data_byte;
                     end
                  end
               end else begin
                  accumulator_in = {accumulator_in[55:0], req.data_byte};
               end
               field_left_in = field_left_in - 4'd1;
               if (field_left_in == 4'd0) begin
                  if (current_type_in == CT_TEXT || current_type_in == CT_BLOB) begin
                     payload_left_in  = accumulator_in;
                     payload_start_in = pos + OFFSET_BITS'(1);
                     if (accumulator_in == 64'd0) begin
                        fin = 1'b1;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end else begin
                     fin = 1'b1;
                  end
               end
            end
            PH_PAYLOAD: begin
               payload_left_in = payload_left_in - 64'd1;
               if (payload_left_in == 64'd0) begin
                  fin = 1'b1;
               end
            end
            default: begin
               fin = 1'b0;
            end
         endcase
      end

      // column result
      if (fin) begin
         skip = !cfg.skip_index[8] && (cfg.skip_index[7:0] == column_number_in);
         col_res.kind         = KIND_COLUMN;
         col_res.column_index = column_number_in;
         if (skip) begin
            if (current_type_in == CT_FLOAT || current_type_in == CT_NEG_FLOAT) begin
               slice = 64'd9;
            end else if (current_type_in <= CT_BLOB) begin
               slice = 64'(type_length_in) + 64'd1;
            end else begin
               slice = 64'd1;
            end
            if (current_type_in == CT_TEXT || current_type_in == CT_BLOB) begin
               slice = slice + accumulator_in;
            end
            col_res.value_type  = VT_SLICE;
            col_res.int_value   = slice;
            col_res.data_offset = buf_offset(cfg.base_offset, column_start_in);
         end else begin
            case (current_type_in)
               CT_NEG_INT: begin
                  col_res.value_type = VT_INTEGER;
                  col_res.int_value  = 64'd0 - accumulator_in;
               end
               CT_INT: begin
                  col_res.value_type = VT_INTEGER;
                  col_res.int_value  = accumulator_in;
               end
               CT_FLOAT: begin
                  col_res.value_type = VT_FLOAT;
                  col_res.float_bits = accumulator_in;
               end
               CT_NEG_FLOAT: begin
                  col_res.value_type = VT_FLOAT;
                  col_res.float_bits = {~accumulator_in[63], accumulator_in[62:0]};
               end
               CT_TEXT: begin
                  col_res.value_type  = VT_TEXT;
                  col_res.int_value   = accumulator_in;
                  col_res.data_offset = buf_offset(cfg.base_offset, payload_start_in);
               end
               CT_BLOB: begin
                  col_res.value_type  = VT_BLOB;
                  col_res.int_value   = accumulator_in;
                  col_res.data_offset = buf_offset(cfg.base_offset, payload_start_in);
               end
               CT_NULL: begin
                  col_res.value_type = VT_NULL;
               end
               default: begin
                  col_res.value_type = VT_INTEGER;
                  col_res.int_value  = {1'b1, 63'd0};
               end
            endcase
         end
         column_number_in = column_number_in + 8'd1;
         columns_left_in  = columns_left_in - 8'd1;
         if (columns_left_in == 8'd0) begin
            done     = 1'b1;
            phase_in = PH_HALT;
         end else begin
            phase_in = PH_TYPE;
         end
      end

      // truncated buffer
      if (active && req.last_byte && phase_in != PH_HALT) begin
         trunc    = 1'b1;
         phase_in = PH_HALT;
      end

      done_res.kind         = KIND_DONE;
      done_res.column_total = column_number_in;
      done_res.end_offset   = buf_offset(cfg.base_offset, byte_position_in);

      err_res.kind         = KIND_ERROR;
      err_res.column_index = column_number_in;
      err_res.error_cause  = ill ? CAUSE_BAD_LENGTH : CAUSE_TRUNCATED;

      // order the results into the two slots
      n = {1'b0, fin} + {1'b0, (done | ill | trunc)};
      if (fin) begin
         push.slot0 = col_res;
      end else if (done) begin
         push.slot0 = done_res;
      end else begin
         push.slot0 = err_res;
      end
      push.slot1 = done ? done_res : err_res;
      if (n == 2'd2) begin
         push.slot1.is_last = 1'b1;
      end else begin
         push.slot0.is_last = 1'b1;
      end
      push.count = in_accept ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         columns_left_ff  <= '0;
         column_number_ff <= '0;
         current_type_ff  <= '0;
         type_length_ff   <= '0;
         field_left_ff    <= '0;
         accumulator_ff   <= '0;
         payload_left_ff  <= '0;
         byte_position_ff <= '0;
         column_start_ff  <= '0;
         payload_start_ff <= '0;
      end else if (in_accept) begin
         phase_ff         <= phase_in;
         columns_left_ff  <= columns_left_in;
         column_number_ff <= column_number_in;
         current_type_ff  <= current_type_in;
         type_length_ff   <= type_length_in;
         field_left_ff    <= field_left_in;
         accumulator_ff   <= accumulator_in;
         payload_left_ff  <= payload_left_in;
         byte_position_ff <= byte_position_in;
         column_start_ff  <= column_start_in;
         payload_start_ff <= payload_start_in;
      end
   end

endmodule

// File: rtl/tcrd_queue.sv
// result queue: takes up to two results a cycle, hands out one per transfer
module tcrd_queue (
   input  logic               clock,
   input  logic               reset,
   input  tcrd_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tcrd_pkg::rsp_type  rsp_data
);
   import tcrd_pkg::*;

   localparam int DEPTH     = 4;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   rsp_type               entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   // room for the worst case of two results from one byte
   assign room      = (count_ff <= CNT_BITS'(DEPTH - 2));

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_BITS'(1)] <= push.slot1;
      end
   end

endmodule

// File: rtl/typed_column_record_decoder.sv
// top level of the typed column record decoder
// a byte's results are registered in the result queue at its transfer and offered on rsp from there
// throughput: one byte per cycle while req_stall is low; a byte gives up to two results,
//   queued four deep, and req_stall rises while fewer than two queue entries are free
// reset: synchronous, clears the parse state to idle, empties the result queue
//   and sets column_count and skip_index to -1 and base_offset to 0
module typed_column_record_decoder #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tcrd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tcrd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [tcrd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tcrd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tcrd_pkg::*;

   cfg_type  cfg;
   push_type push;
   logic     room;
   logic     in_accept;

   // input transfer
   assign req_stall = !room;
   assign in_accept = req_valid && room;

   tcrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tcrd_parse #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_accept (in_accept),
      .req       (req_data),
      .push      (push)
   );

   tcrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
